// ----- hdl/rgbhsv_pkg.sv -----
// ============================================================================
// rgbhsv_pkg - shared types and constants for the RGB to HSV converter
// Holds the pipeline payload, the sector codes and the hue scale constants.
// ============================================================================
package rgbhsv_pkg;

    // Hue scale: 1/64 degree units
    localparam logic [14:0] HUE_FULL_TURN  = 15'd23040;
    localparam logic [14:0] HUE_TWO_THIRDS = 15'd15360;
    localparam logic [14:0] HUE_ONE_THIRD  = 15'd7680;
    localparam logic [11:0] HUE_SIXTH      = 12'd3840;
    localparam logic [7:0]  SAT_SCALE      = 8'd255;

    // Divider layout
    localparam int DIV_STAGES = 4;
    localparam int HUE_Q_W    = 12;
    localparam int SAT_Q_W    = 8;
    localparam int HUE_STEPS  = HUE_Q_W / DIV_STAGES;
    localparam int SAT_STEPS  = SAT_Q_W / DIV_STAGES;

    // Sector codes: {red/green swap, green/blue swap}
    localparam logic [1:0] SEC_NONE = 2'b00;
    localparam logic [1:0] SEC_GB   = 2'b01;
    localparam logic [1:0] SEC_RG   = 2'b10;
    localparam logic [1:0] SEC_BOTH = 2'b11;

    // Payload carried down the pipeline
    typedef struct packed {
        logic [7:0]         chroma;
        logic [7:0]         vmax;
        logic [7:0]         alpha;
        logic [1:0]         sector;
        logic               sub;
        logic [7:0]         h_rem;
        logic [HUE_Q_W-1:0] h_work;
        logic [7:0]         s_rem;
        logic [SAT_Q_W-1:0] s_work;
    } pix_t;

    // Hue base angle of a sector
    function automatic logic [14:0] hue_base(input logic [1:0] sector);
        logic [14:0] base;
        base = '0;
        unique case (sector)
            SEC_NONE: base = '0;
            SEC_GB:   base = HUE_FULL_TURN;
            SEC_RG:   base = HUE_ONE_THIRD;
            SEC_BOTH: base = HUE_TWO_THIRDS;
            default:  base = '0;
        endcase
        return base;
    endfunction

endpackage

// ----- hdl/rgbhsv_front.sv -----
// ============================================================================
// rgbhsv_front - sort stage
// Swaps channels to find the maximum and sector, forms chroma and the
// dividends for the hue and saturation dividers.
// ============================================================================
module rgbhsv_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pixel_valid,
    output logic               pixel_stall,
    input  logic [7:0]         red,
    input  logic [7:0]         green,
    input  logic [7:0]         blue,
    input  logic [7:0]         alpha,
    output logic               down_valid,
    output rgbhsv_pkg::pix_t   down_data,
    input  logic               down_stall
);

    logic             valid_reg;
    logic             valid_next;
    logic             load;
    rgbhsv_pkg::pix_t data_reg;
    rgbhsv_pkg::pix_t data_next;

    logic             swap_gb;
    logic             swap_rg;
    logic [7:0]       g1;
    logic [7:0]       b1;
    logic [7:0]       r2;
    logic [7:0]       g2;
    logic [7:0]       lo;
    logic [7:0]       chroma;
    logic [8:0]       diff;
    logic             d_neg;
    logic [7:0]       d_abs;
    logic [19:0]      num_h;
    logic [15:0]      num_s;

    // Swap network and sector
    always_comb
    begin
        swap_gb = (green < blue);
        g1      = swap_gb ? blue : green;
        b1      = swap_gb ? green : blue;
        swap_rg = (red < g1);
        r2      = swap_rg ? g1 : red;
        g2      = swap_rg ? red : g1;
        lo      = (g2 < b1) ? g2 : b1;
        chroma  = r2 - lo;
        diff    = {1'b0, g2} - {1'b0, b1};
        d_neg   = diff[8];
        d_abs   = d_neg ? 8'(-diff) : diff[7:0];
        num_h   = 20'(d_abs) * 20'(rgbhsv_pkg::HUE_SIXTH);
        num_s   = 16'(chroma) * 16'(rgbhsv_pkg::SAT_SCALE);
    end

    // Beat payload for the dividers
    always_comb
    begin
        data_next.chroma = chroma;
        data_next.vmax   = r2;
        data_next.alpha  = alpha;
        data_next.sector = {swap_rg, swap_gb};
        case ({swap_rg, swap_gb})
            rgbhsv_pkg::SEC_GB:   data_next.sub = 1'b1;
            rgbhsv_pkg::SEC_RG:   data_next.sub = !d_neg;
            rgbhsv_pkg::SEC_BOTH: data_next.sub = d_neg;
            default:              data_next.sub = 1'b0;
        endcase
        data_next.h_rem  = num_h[19:12];
        data_next.h_work = num_h[11:0];
        data_next.s_rem  = num_s[15:8];
        data_next.s_work = num_s[7:0];
    end

    // Stage handshake
    assign load        = !valid_reg || !down_stall;
    assign pixel_stall = !load;
    assign valid_next  = load ? pixel_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && pixel_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

// ----- hdl/rgbhsv_div_stage.sv -----
// ============================================================================
// rgbhsv_div_stage - one slice of the restoring dividers
// Retires three hue quotient bits and two saturation quotient bits.
// ============================================================================
module rgbhsv_div_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_stall,
    input  rgbhsv_pkg::pix_t up_data,
    output logic             down_valid,
    output rgbhsv_pkg::pix_t down_data,
    input  logic             down_stall
);

    logic             valid_reg;
    logic             valid_next;
    logic             load;
    rgbhsv_pkg::pix_t data_reg;
    rgbhsv_pkg::pix_t data_next;

    // Shift-subtract steps, hue by chroma and saturation by max
    always_comb
    begin
        logic [7:0]                    rem_h;
        logic [rgbhsv_pkg::HUE_Q_W-1:0] work_h;
        logic [8:0]                    t_h;
        logic [8:0]                    d_h;
        logic [7:0]                    rem_s;
        logic [rgbhsv_pkg::SAT_Q_W-1:0] work_s;
        logic [8:0]                    t_s;
        logic [8:0]                    d_s;
        logic                          qb;

        rem_h  = up_data.h_rem;
        work_h = up_data.h_work;
        rem_s  = up_data.s_rem;
        work_s = up_data.s_work;
        for (int i = 0; i < rgbhsv_pkg::HUE_STEPS; i++)
        begin
            t_h    = {rem_h, work_h[rgbhsv_pkg::HUE_Q_W-1]};
            d_h    = t_h - {1'b0, up_data.chroma};
            qb     = (t_h >= {1'b0, up_data.chroma});
            rem_h  = qb ? d_h[7:0] : t_h[7:0];
            work_h = {work_h[rgbhsv_pkg::HUE_Q_W-2:0], qb};
        end
        for (int j = 0; j < rgbhsv_pkg::SAT_STEPS; j++)
        begin
            t_s    = {rem_s, work_s[rgbhsv_pkg::SAT_Q_W-1]};
            d_s    = t_s - {1'b0, up_data.vmax};
            qb     = (t_s >= {1'b0, up_data.vmax});
            rem_s  = qb ? d_s[7:0] : t_s[7:0];
            work_s = {work_s[rgbhsv_pkg::SAT_Q_W-2:0], qb};
        end
        data_next        = up_data;
        data_next.h_rem  = rem_h;
        data_next.h_work = work_h;
        data_next.s_rem  = rem_s;
        data_next.s_work = work_s;
    end

    // Stage handshake
    assign load       = !valid_reg || !down_stall;
    assign up_stall   = !load;
    assign valid_next = load ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_data  = data_reg;

endmodule

// ----- hdl/rgbhsv_back.sv -----
// ============================================================================
// rgbhsv_back - hue assembly and output register
// Combines sector base and quotient into the hue, applies the zero cases.
// ============================================================================
module rgbhsv_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             up_valid,
    output logic             up_stall,
    input  rgbhsv_pkg::pix_t up_data,
    output logic             hsv_valid,
    input  logic             hsv_stall,
    output logic [14:0]      hue,
    output logic [7:0]       saturation,
    output logic [7:0]       brightness,
    output logic [7:0]       alpha_out
);

    logic        valid_reg;
    logic        valid_next;
    logic        load;
    logic [14:0] hue_reg;
    logic [14:0] hue_next;
    logic [7:0]  sat_reg;
    logic [7:0]  sat_next;
    logic [7:0]  val_reg;
    logic [7:0]  alpha_reg;

    logic [14:0] base;
    logic [14:0] up_sum;
    logic [14:0] down_diff;
    logic        rem_nz;

    // Hue from sector base plus or minus the scaled channel difference
    always_comb
    begin
        base      = rgbhsv_pkg::hue_base(up_data.sector);
        rem_nz    = (up_data.h_rem != 8'd0);
        up_sum    = base + 15'(up_data.h_work);
        down_diff = base - 15'(up_data.h_work) - 15'(rem_nz);
        if (up_data.chroma == 8'd0)
        begin
            hue_next = '0;
        end
        else if (up_data.sub)
        begin
            hue_next = (down_diff == rgbhsv_pkg::HUE_FULL_TURN) ? 15'd0 : down_diff;
        end
        else
        begin
            hue_next = up_sum;
        end
        sat_next = (up_data.vmax == 8'd0) ? 8'd0 : up_data.s_work;
    end

    // Output handshake
    assign load       = !valid_reg || !hsv_stall;
    assign up_stall   = !load;
    assign valid_next = load ? up_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && up_valid)
        begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            val_reg   <= up_data.vmax;
            alpha_reg <= up_data.alpha;
        end
    end

    assign hsv_valid  = valid_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = val_reg;
    assign alpha_out  = alpha_reg;

endmodule

// ----- hdl/rgb_to_hsv_converter.sv -----
// ============================================================================
// rgb_to_hsv_converter - pipelined RGBA to HSV pixel converter
// Swap-based hue sector search and pipelined restoring dividers.
// ============================================================================
// Usage:
//   Pixel channel: pixel_valid/pixel_stall with red, green, blue, alpha.
//   A beat is taken on a clock edge with pixel_valid high and pixel_stall low.
//   HSV channel: hsv_valid/hsv_stall with hue (1/64 degree), saturation,
//   brightness and alpha_out (alpha copied through).
//   The pipeline has one sort stage, four divider stages, each retiring
//   three hue and two saturation quotient bits, and the output register.
//   Throughput is one pixel per clock while hsv_stall is low; the divider stages set the depth.
//   Each stage holds a valid bit, so bubbles close up: while hsv_stall is
//   high, the pipeline keeps taking pixels until every stage is full, then
//   raises pixel_stall. A stalled output beat holds steady.
//   Reset (rst_n low, asynchronous) clears all valid bits; no pixels are
//   in flight afterwards and the block accepts input at once.
// ============================================================================
module rgb_to_hsv_converter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_stall,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  alpha,
    output logic        hsv_valid,
    input  logic        hsv_stall,
    output logic [14:0] hue,
    output logic [7:0]  saturation,
    output logic [7:0]  brightness,
    output logic [7:0]  alpha_out
);

    logic [rgbhsv_pkg::DIV_STAGES:0] st_valid;
    logic [rgbhsv_pkg::DIV_STAGES:0] st_stall;
    rgbhsv_pkg::pix_t                st_data [rgbhsv_pkg::DIV_STAGES+1];

    // Sort stage
    rgbhsv_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .red         (red),
        .green       (green),
        .blue        (blue),
        .alpha       (alpha),
        .down_valid  (st_valid[0]),
        .down_data   (st_data[0]),
        .down_stall  (st_stall[0])
    );

    // Divider stages
    for (genvar k = 0; k < rgbhsv_pkg::DIV_STAGES; k++)
    begin : g_div
        rgbhsv_div_stage u_div (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (st_valid[k]),
            .up_stall   (st_stall[k]),
            .up_data    (st_data[k]),
            .down_valid (st_valid[k+1]),
            .down_data  (st_data[k+1]),
            .down_stall (st_stall[k+1])
        );
    end

    // Hue assembly and output register
    rgbhsv_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (st_valid[rgbhsv_pkg::DIV_STAGES]),
        .up_stall   (st_stall[rgbhsv_pkg::DIV_STAGES]),
        .up_data    (st_data[rgbhsv_pkg::DIV_STAGES]),
        .hsv_valid  (hsv_valid),
        .hsv_stall  (hsv_stall),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness),
        .alpha_out  (alpha_out)
    );

endmodule

// ----- hdl/rgbhsv_checker.sv -----
// ============================================================================
// rgbhsv_checker - port-level checks for the RGB to HSV converter
// Watches the top level ports; attached by bind.
// ============================================================================
module rgbhsv_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        pixel_valid,
    input logic        pixel_stall,
    input logic        hsv_valid,
    input logic        hsv_stall,
    input logic [14:0] hue,
    input logic [7:0]  saturation,
    input logic [7:0]  brightness,
    input logic [7:0]  alpha_out
);

    // A stalled output beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && hsv_stall |=> hsv_valid &&
            $stable({hue, saturation, brightness, alpha_out}))
        else $error("stalled HSV beat changed");

    // A stalled pixel beat stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && pixel_stall |=> pixel_valid)
        else $error("stalled pixel beat withdrawn");

    // Hue stays below a full turn
    assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid |-> (hue < rgbhsv_pkg::HUE_FULL_TURN))
        else $error("hue out of range");

    // Black has no saturation
    assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && (brightness == 8'd0) |-> (saturation == 8'd0))
        else $error("saturation nonzero on black");

    // An empty or draining output never backs up the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !hsv_valid || !hsv_stall |-> !pixel_stall)
        else $error("input stalled while output drains");

endmodule

bind rgb_to_hsv_converter rgbhsv_checker u_rgbhsv_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .hsv_valid   (hsv_valid),
    .hsv_stall   (hsv_stall),
    .hue         (hue),
    .saturation  (saturation),
    .brightness  (brightness),
    .alpha_out   (alpha_out)
);
